// ===== src/owtr_pkg.sv =====
// ----------------------------------------------------------------------------
// owtr_pkg
// Types and constants shared by the one-wire temperature reader modules.
// ----------------------------------------------------------------------------
package owtr_pkg;

  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 20;

  localparam logic [CfgIndexBits-1:0] CfgResetLow   = 3'd0;
  localparam logic [CfgIndexBits-1:0] CfgPresSample = 3'd1;
  localparam logic [CfgIndexBits-1:0] CfgResetTail  = 3'd2;
  localparam logic [CfgIndexBits-1:0] CfgSlot       = 3'd3;
  localparam logic [CfgIndexBits-1:0] CfgCmdGap     = 3'd4;
  localparam logic [CfgIndexBits-1:0] CfgConvWait   = 3'd5;
  localparam logic [CfgIndexBits-1:0] CfgFinalWait  = 3'd6;

  localparam logic [9:0]  ResetLowDefault   = 10'd480;
  localparam logic [7:0]  PresSampleDefault = 8'd80;
  localparam logic [9:0]  ResetTailDefault  = 10'd400;
  localparam logic [7:0]  SlotDefault       = 8'd50;
  localparam logic [19:0] CmdGapDefault     = 20'd1000;
  localparam logic [19:0] ConvWaitDefault   = 20'd800000;
  localparam logic [19:0] FinalWaitDefault  = 20'd1000000;

  localparam logic [7:0] CmdSkipRom  = 8'hCC;
  localparam logic [7:0] CmdConvert  = 8'h44;
  localparam logic [7:0] CmdReadPad  = 8'hBE;

  typedef enum logic [4:0] {
    PhIdle,
    PhR1Low,
    PhR1Wait,
    PhR1Tail,
    PhGap1,
    PhW1Low,
    PhW1Rel,
    PhConv,
    PhR2Low,
    PhR2Wait,
    PhR2Tail,
    PhGap2,
    PhW2Low,
    PhW2Rel,
    PhRdLow,
    PhRdRel,
    PhFinal
  } phase_e;

  typedef struct packed {
    logic [9:0]  reset_low;
    logic [7:0]  pres_sample;
    logic [9:0]  reset_tail;
    logic [7:0]  slot;
    logic [19:0] cmd_gap;
    logic [19:0] conv_wait;
    logic [19:0] final_wait;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  shift;
    logic [2:0]  bit_idx;
    logic        byte_idx;
  } seq_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               presence_ok;
    logic signed [15:0] temperature_raw;
  } res_t;

endpackage

// ===== src/owtr_core.sv =====
// ----------------------------------------------------------------------------
// owtr_core
// Bus sequencer: advances the read sequence by one tick per accepted item.
// ----------------------------------------------------------------------------
module owtr_core import owtr_pkg::*; #(
  parameter int unsigned TickCounterBits = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic start_i,
  input  logic line_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam int unsigned CntW = TickCounterBits;
  localparam logic [32:0] CntMax = (33'd1 << CntW) - 33'd1;
  localparam logic [CntW-1:0] CntOne = {{(CntW-1){1'b0}}, 1'b1};

  function automatic logic [CntW-1:0] sat_ticks(input logic [19:0] v);
    logic [32:0] wide;
    wide = {13'd0, v};
    if (wide > CntMax) begin
      sat_ticks = CntMax[CntW-1:0];
    end else begin
      sat_ticks = wide[CntW-1:0];
    end
  endfunction

  function automatic seq_t next_phase(input seq_t s);
    seq_t n;
    n = s;
    case (s.phase)
      PhR1Low:  n.phase = PhR1Wait;
      PhR1Wait: n.phase = PhR1Tail;
      PhR1Tail: n.phase = PhGap1;
      PhR2Low:  n.phase = PhR2Wait;
      PhR2Wait: n.phase = PhR2Tail;
      PhR2Tail: n.phase = PhGap2;
      PhW1Low:  n.phase = PhW1Rel;
      PhW2Low:  n.phase = PhW2Rel;
      PhConv:   n.phase = PhR2Low;
      PhRdLow:  n.phase = PhRdRel;
      PhGap1, PhGap2: begin
        n.phase    = (s.phase == PhGap1) ? PhW1Low : PhW2Low;
        n.shift    = CmdSkipRom;
        n.bit_idx  = 3'd0;
        n.byte_idx = 1'b0;
      end
      PhW1Rel, PhW2Rel: begin
        n.shift = {1'b0, s.shift[7:1]};
        if (s.bit_idx != 3'd7) begin
          n.bit_idx = s.bit_idx + 3'd1;
          n.phase   = (s.phase == PhW1Rel) ? PhW1Low : PhW2Low;
        end else if (!s.byte_idx) begin
          n.bit_idx  = 3'd0;
          n.byte_idx = 1'b1;
          n.shift    = (s.phase == PhW1Rel) ? CmdConvert : CmdReadPad;
          n.phase    = (s.phase == PhW1Rel) ? PhW1Low : PhW2Low;
        end else begin
          n.bit_idx  = 3'd0;
          n.byte_idx = 1'b0;
          n.shift    = 8'd0;
          n.phase    = (s.phase == PhW1Rel) ? PhConv : PhRdLow;
        end
      end
      PhRdRel: begin
        if (s.bit_idx != 3'd7) begin
          n.bit_idx = s.bit_idx + 3'd1;
          n.phase   = PhRdLow;
        end else if (!s.byte_idx) begin
          n.bit_idx  = 3'd0;
          n.byte_idx = 1'b1;
          n.shift    = 8'd0;
          n.phase    = PhRdLow;
        end else begin
          n.bit_idx  = 3'd0;
          n.byte_idx = 1'b0;
          n.phase    = PhFinal;
        end
      end
      default: n.phase = PhIdle;
    endcase
    return n;
  endfunction

  logic [CntW-1:0] dur_rlow, dur_pres, dur_tail, dur_slot;
  logic [CntW-1:0] dur_gap, dur_conv, dur_final;

  assign dur_rlow  = sat_ticks((cfg_i.reset_low == '0) ? 20'd1 : {10'd0, cfg_i.reset_low});
  assign dur_pres  = sat_ticks((cfg_i.pres_sample == '0) ? 20'd1 : {12'd0, cfg_i.pres_sample});
  assign dur_tail  = sat_ticks((cfg_i.reset_tail == '0) ? 20'd1 : {10'd0, cfg_i.reset_tail});
  assign dur_slot  = sat_ticks((cfg_i.slot == '0) ? 20'd1 : {12'd0, cfg_i.slot});
  assign dur_gap   = sat_ticks(cfg_i.cmd_gap);
  assign dur_conv  = sat_ticks(cfg_i.conv_wait);
  assign dur_final = sat_ticks(cfg_i.final_wait);

  seq_t               seq_q, seq_d;
  logic [CntW-1:0]    tick_q, tick_d;
  logic [7:0]         low_q, low_d;
  logic signed [15:0] temp_q, temp_d;
  logic               pres_q, pres_d;

  seq_t            cur;
  seq_t            nxt;
  logic [CntW-1:0] tick_inc;
  logic [CntW-1:0] ticks;
  logic            busy;
  logic            drive;
  logic            done;
  logic            skip;

  always_comb begin
    cur    = seq_q;
    tick_d = tick_q;
    low_d  = low_q;
    temp_d = temp_q;
    pres_d = pres_q;
    done   = 1'b0;
    ticks  = '0;
    nxt    = seq_q;
    skip   = 1'b0;

    if (cur.phase == PhIdle && start_i) begin
      cur.phase    = PhR1Low;
      cur.shift    = 8'd0;
      cur.bit_idx  = 3'd0;
      cur.byte_idx = 1'b0;
      tick_d       = '0;
    end

    busy  = (cur.phase != PhIdle);
    drive = (cur.phase == PhR1Low) || (cur.phase == PhR2Low) || (cur.phase == PhW1Low) ||
            (cur.phase == PhW2Low) || (cur.phase == PhRdLow);

    if (tick_d == '0) begin
      if (cur.phase == PhR1Tail || cur.phase == PhR2Tail) begin
        pres_d = ~line_i;
      end
      if (cur.phase == PhRdRel) begin
        cur.shift = {line_i, cur.shift[7:1]};
        if (cur.bit_idx == 3'd7) begin
          if (!cur.byte_idx) begin
            low_d = cur.shift;
          end else begin
            temp_d = {cur.shift, low_q};
            done   = 1'b1;
          end
        end
      end
    end

    case (cur.phase)
      PhR1Low, PhR2Low:   ticks = dur_rlow;
      PhR1Wait, PhR2Wait: ticks = dur_pres;
      PhR1Tail, PhR2Tail: ticks = dur_tail;
      PhGap1, PhGap2:     ticks = dur_gap;
      PhW1Low, PhW2Low:   ticks = cur.shift[0] ? CntOne : dur_slot;
      PhW1Rel, PhW2Rel:   ticks = cur.shift[0] ? dur_slot : CntOne;
      PhConv:             ticks = dur_conv;
      PhRdLow:            ticks = CntOne;
      PhRdRel:            ticks = dur_slot;
      PhFinal:            ticks = dur_final;
      default:            ticks = '0;
    endcase

    tick_inc = tick_d + CntOne;
    nxt      = cur;
    if (busy) begin
      if (tick_inc >= ticks) begin
        tick_d = '0;
        nxt    = next_phase(cur);
        case (nxt.phase)
          PhGap1, PhGap2: skip = (dur_gap == '0);
          PhConv:         skip = (dur_conv == '0);
          PhFinal:        skip = (dur_final == '0);
          default:        skip = 1'b0;
        endcase
        if (skip) begin
          nxt = next_phase(nxt);
        end
      end else begin
        tick_d = tick_inc;
      end
    end
    seq_d = nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= '{phase: PhIdle, shift: 8'd0, bit_idx: 3'd0, byte_idx: 1'b0};
      tick_q <= '0;
      low_q  <= 8'd0;
      temp_q <= 16'sd0;
      pres_q <= 1'b0;
    end else if (step_i) begin
      seq_q  <= seq_d;
      tick_q <= tick_d;
      low_q  <= low_d;
      temp_q <= temp_d;
      pres_q <= pres_d;
    end
  end

  assign res_o.drive_low       = drive;
  assign res_o.busy_res        = busy;
  assign res_o.done_res        = done;
  assign res_o.presence_ok     = pres_d;
  assign res_o.temperature_raw = temp_d;

endmodule

// ===== src/owtr_obuf.sv =====
// ----------------------------------------------------------------------------
// owtr_obuf
// Two-entry result buffer between the sequencer and the output stream.
// ----------------------------------------------------------------------------
module owtr_obuf import owtr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_ready_i,
  output res_t data_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop     = valid_o && pop_ready_i;
  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/one_wire_temperature_reader.sv =====
// ----------------------------------------------------------------------------
// one_wire_temperature_reader
// One-wire bus master that reads a temperature sensor, one bus tick per item.
// ----------------------------------------------------------------------------
// Each input transaction on the s_ stream is one microsecond of bus time and
// carries the start request and the sampled line level. Each one produces
// exactly one output transaction on the m_ stream with the pull-down enable,
// busy and done flags, the presence flag and the raw signed temperature.
// The tick is processed in the cycle it is accepted and its result sits in
// the output buffer on the next cycle. One transaction is taken every cycle
// while the output buffer has room. The rate is set by the single sequencer
// register stage and its tick counter compare.
// The output buffer holds two results, so input is still taken while one
// result waits; s_tready falls only when both entries are full. The user
// writes timing registers through the cfg_ channel only while the sequence
// is idle, unenforced by the block; a write lands when cfg_valid_i is high.
// Reset returns the sequencer to idle, clears the temperature and presence
// flag, empties the buffer and loads the default timing registers.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader import owtr_pkg::*; #(
  parameter int unsigned TickCounterBits = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // [0] start_req, [1] line_level, [7:2] zero
  input  logic [7:0]              s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] presence_ok,
  // [19:4] temperature_raw, [23:20] zero
  output logic [23:0]             m_tdata,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i
);

  cfg_t cfg_q;
  res_t res;
  res_t res_out;
  logic step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low   <= ResetLowDefault;
      cfg_q.pres_sample <= PresSampleDefault;
      cfg_q.reset_tail  <= ResetTailDefault;
      cfg_q.slot        <= SlotDefault;
      cfg_q.cmd_gap     <= CmdGapDefault;
      cfg_q.conv_wait   <= ConvWaitDefault;
      cfg_q.final_wait  <= FinalWaitDefault;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgResetLow:   cfg_q.reset_low   <= cfg_data_i[9:0];
        CfgPresSample: cfg_q.pres_sample <= cfg_data_i[7:0];
        CfgResetTail:  cfg_q.reset_tail  <= cfg_data_i[9:0];
        CfgSlot:       cfg_q.slot        <= cfg_data_i[7:0];
        CfgCmdGap:     cfg_q.cmd_gap     <= cfg_data_i;
        CfgConvWait:   cfg_q.conv_wait   <= cfg_data_i;
        CfgFinalWait:  cfg_q.final_wait  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign step = s_tvalid && s_tready;

  owtr_core #(
    .TickCounterBits(TickCounterBits)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .start_i(s_tdata[0]),
    .line_i (s_tdata[1]),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  owtr_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step),
    .data_i     (res),
    .ready_o    (s_tready),
    .valid_o    (m_tvalid),
    .pop_ready_i(m_tready),
    .data_o     (res_out)
  );

  assign m_tdata = {4'd0, res_out.temperature_raw, res_out.presence_ok, res_out.done_res,
                    res_out.busy_res, res_out.drive_low};

endmodule

// ===== src/owtr_checker.sv =====
// ----------------------------------------------------------------------------
// owtr_checker
// Port-level checks for the one-wire temperature reader.
// ----------------------------------------------------------------------------
module owtr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("Done reported outside a read sequence.");

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("Bus driven low while idle.");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid |-> s_tready)
    else $error("Input stalled with an empty output buffer.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output transaction changed.");

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the one-wire temperature reader.
// ----------------------------------------------------------------------------
// A built-in sensor model answers each bus tick with the presence level and
// the temperature bits that the bench picks. A cycle-level model of the
// sequencer predicts every output transaction, and each one is compared field
// by field. The timing registers run through zeros, small fixed settings, one
// longer fixed setting and many small random settings. Both streams stall at
// random.
// ----------------------------------------------------------------------------
module tb_top import owtr_pkg::*; ();

  localparam logic [CfgIndexBits-1:0] CfgNone = 3'd7;

  class reader_scoreboard;
    cfg_t        timing;
    phase_e      ph;
    int unsigned tick_cnt;
    logic [7:0]  shift;
    logic [2:0]  bit_idx;
    logic        byte_idx;
    logic [7:0]  low_byte;
    logic [15:0] temp_hold;
    logic        present_flag;
    res_t        bus_results[$];
    int          errors;
    int          reads;

    function new();
      timing.reset_low   = ResetLowDefault;
      timing.pres_sample = PresSampleDefault;
      timing.reset_tail  = ResetTailDefault;
      timing.slot        = SlotDefault;
      timing.cmd_gap     = CmdGapDefault;
      timing.conv_wait   = ConvWaitDefault;
      timing.final_wait  = FinalWaitDefault;
      ph = PhIdle;
      tick_cnt = 0;
      shift = '0;
      bit_idx = '0;
      byte_idx = 1'b0;
      low_byte = '0;
      temp_hold = '0;
      present_flag = 1'b0;
      errors = 0;
      reads = 0;
    endfunction

    function void set_timing(logic [CfgIndexBits-1:0] idx, logic [CfgDataBits-1:0] val);
      case (idx)
        CfgResetLow:   timing.reset_low = val[9:0];
        CfgPresSample: timing.pres_sample = val[7:0];
        CfgResetTail:  timing.reset_tail = val[9:0];
        CfgSlot:       timing.slot = val[7:0];
        CfgCmdGap:     timing.cmd_gap = val;
        CfgConvWait:   timing.conv_wait = val;
        CfgFinalWait:  timing.final_wait = val;
        default: ;
      endcase
    endfunction

    function int unsigned at_least_one(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    function int unsigned dur();
      case (ph)
        PhR1Low, PhR2Low:   return at_least_one(timing.reset_low);
        PhR1Wait, PhR2Wait: return at_least_one(timing.pres_sample);
        PhR1Tail, PhR2Tail: return at_least_one(timing.reset_tail);
        PhGap1, PhGap2:     return timing.cmd_gap;
        PhW1Low, PhW2Low:   return shift[0] ? 1 : at_least_one(timing.slot);
        PhW1Rel, PhW2Rel:   return shift[0] ? at_least_one(timing.slot) : 1;
        PhConv:             return timing.conv_wait;
        PhRdLow:            return 1;
        PhRdRel:            return at_least_one(timing.slot);
        PhFinal:            return timing.final_wait;
        default:            return 0;
      endcase
    endfunction

    function bit drives_low();
      return ph == PhR1Low || ph == PhR2Low || ph == PhW1Low || ph == PhW2Low ||
             ph == PhRdLow;
    endfunction

    function void next_phase();
      phase_e write_low;
      write_low = (ph == PhW1Rel) ? PhW1Low : PhW2Low;
      case (ph)
        PhGap1, PhGap2: begin
          ph = (ph == PhGap1) ? PhW1Low : PhW2Low;
          shift = CmdSkipRom;
          bit_idx = '0;
          byte_idx = 1'b0;
        end
        PhW1Rel, PhW2Rel: begin
          shift = shift >> 1;
          if (bit_idx < 7) begin
            bit_idx++;
            ph = write_low;
          end else if (!byte_idx) begin
            bit_idx = '0;
            byte_idx = 1'b1;
            shift = (ph == PhW1Rel) ? CmdConvert : CmdReadPad;
            ph = write_low;
          end else begin
            bit_idx = '0;
            byte_idx = 1'b0;
            shift = '0;
            ph = (ph == PhW1Rel) ? PhConv : PhRdLow;
          end
        end
        PhRdRel: begin
          if (bit_idx < 7) begin
            bit_idx++;
            ph = PhRdLow;
          end else if (!byte_idx) begin
            bit_idx = '0;
            byte_idx = 1'b1;
            shift = '0;
            ph = PhRdLow;
          end else begin
            bit_idx = '0;
            byte_idx = 1'b0;
            ph = PhFinal;
          end
        end
        PhFinal: ph = PhIdle;
        default: ph = phase_e'(ph + 5'd1);
      endcase
    endfunction

    // Level that a well-behaved sensor would leave on the bus for the next tick.
    function bit bus_level(logic [15:0] t, bit present);
      if (tick_cnt == 0 && (ph == PhR1Tail || ph == PhR2Tail)) return !present;
      if (tick_cnt == 0 && ph == PhRdRel) return t[{byte_idx, bit_idx}];
      return !drives_low();
    endfunction

    function bit idle();
      return ph == PhIdle;
    endfunction

    function int pending();
      return bus_results.size();
    endfunction

    function void note_tick(bit start, bit line);
      res_t r;
      r = '0;
      if (ph == PhIdle && start) begin
        ph = PhR1Low;
        tick_cnt = 0;
        shift = '0;
        bit_idx = '0;
        byte_idx = 1'b0;
      end
      if (ph != PhIdle) begin
        r.busy_res = 1'b1;
        r.drive_low = drives_low();
        if (tick_cnt == 0) begin
          if (ph == PhR1Tail || ph == PhR2Tail) present_flag = !line;
          if (ph == PhRdRel) begin
            shift = {line, shift[7:1]};
            if (bit_idx == 7) begin
              if (!byte_idx) begin
                low_byte = shift;
              end else begin
                temp_hold = {shift, low_byte};
                r.done_res = 1'b1;
                reads++;
              end
            end
          end
        end
        tick_cnt++;
        if (tick_cnt >= dur()) begin
          tick_cnt = 0;
          do next_phase(); while (ph != PhIdle && dur() == 0);
        end
      end
      r.presence_ok = present_flag;
      r.temperature_raw = temp_hold;
      bus_results.push_back(r);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [23:0] d);
      res_t e;
      if (bus_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, d);
        return;
      end
      e = bus_results.pop_front();
      compare("drive_low", e.drive_low, d[0]);
      compare("busy_res", e.busy_res, d[1]);
      compare("done_res", e.done_res, d[2]);
      compare("presence_ok", e.presence_ok, d[3]);
      compare("temperature_raw", e.temperature_raw, d[19:4]);
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_tvalid;
  logic                    s_tready;
  // [0] start_req, [1] line_level, [7:2] zero
  logic [7:0]              s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  // [0] drive_low, [1] busy_res, [2] done_res, [3] presence_ok,
  // [19:4] temperature_raw, [23:20] zero
  logic [23:0]             m_tdata;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIndexBits-1:0] cfg_index_i;
  logic [CfgDataBits-1:0]  cfg_data_i;

  reader_scoreboard sb;
  bit idling;
  int n_ticks;
  int n_results;

  one_wire_temperature_reader uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic send_tick(bit start, bit line);
    int gap;
    gap = 0;
    if (idling && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata = {6'b0, line, start};
    forever begin
      @(posedge clk_i);
      if (s_tready) break;
    end
    sb.note_tick(start, line);
    n_ticks++;
  endtask

  task automatic settle();
    while (!sb.idle()) send_tick(1'b0, 1'($urandom_range(0, 1)));
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIndexBits-1:0] idx, logic [CfgDataBits-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.set_timing(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // The narrow registers get random upper bits, which the block must drop.
  task automatic load_timing(logic [9:0] rl, logic [7:0] ps, logic [9:0] rt, logic [7:0] sl,
                             logic [19:0] gap, logic [19:0] conv, logic [19:0] fin);
    logic [19:0] junk;
    settle();
    junk = 20'($urandom);
    write_reg(CfgResetLow, {junk[19:10], rl});
    write_reg(CfgPresSample, {junk[11:0], ps});
    write_reg(CfgResetTail, {junk[9:0], rt});
    write_reg(CfgSlot, {junk[15:4], sl});
    write_reg(CfgCmdGap, gap);
    write_reg(CfgConvWait, conv);
    write_reg(CfgFinalWait, fin);
  endtask

  task automatic run_read(logic [15:0] t, bit present, bit noisy, bit hold_start);
    bit line;
    bit start;
    start = 1'b1;
    do begin
      line = sb.bus_level(t, present);
      if (noisy && $urandom_range(0, 3) == 0) line = 1'($urandom_range(0, 1));
      send_tick(start, line);
      start = hold_start || $urandom_range(0, 7) == 0;
    end while (!sb.idle());
  endtask

  initial begin : drain
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    m_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        m_tready = 1'b0;
        hold--;
      end else if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        stall = $urandom_range(0, 15);
      end else begin
        m_tready = 1'b1;
      end
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        n_results++;
        if (n_results == 300 || n_results == 6000) hold = 100;
      end
    end
  end

  initial begin
    #100_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    idling = 1'b1;
    n_ticks = 0;
    n_results = 0;
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    repeat (4) send_tick(1'b0, 1'($urandom_range(0, 1)));

    load_timing(3, 2, 3, 2, 2, 3, 2);
    run_read(16'h7FFF, 1'b1, 1'b0, 1'b1);
    run_read(16'h8000, 1'b0, 1'b0, 1'b0);

    load_timing(0, 0, 0, 0, 0, 0, 0);
    write_reg(CfgNone, 20'($urandom));
    run_read(16'h0000, 1'b1, 1'b0, 1'b0);
    run_read(16'hFFFF, 1'b1, 1'b0, 1'b1);

    load_timing(10'd24, 8'd9, 10'd17, 8'd3, 20'd5, 20'd11, 20'd6);
    run_read(16'h5A3C, 1'b1, 1'b0, 1'b0);

    while (n_ticks < 900) begin
      load_timing(10'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                  10'($urandom_range(0, 4)), 8'($urandom_range(0, 3)),
                  20'($urandom_range(0, 3)), 20'($urandom_range(0, 3)),
                  20'($urandom_range(0, 3)));
      idling = $urandom_range(0, 3) != 0;
      repeat (2) begin
        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
        run_read(16'($urandom), $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
                 $urandom_range(0, 5) == 0);
      end
    end

    idling = 1'b0;
    load_timing(1, 1, 1, 1, 0, 0, 5);
    run_read(16'($urandom), 1'b1, 1'b0, 1'b0);

    load_timing(10'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                10'($urandom_range(1, 4)), 8'($urandom_range(1, 3)),
                20'($urandom_range(0, 3)), 20'($urandom_range(0, 3)),
                20'($urandom_range(0, 3)));
    run_read(16'($urandom), 1'b1, 1'b0, 1'b0);

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/owtr_pkg.sv
src/owtr_core.sv
src/owtr_obuf.sv
src/one_wire_temperature_reader.sv
src/owtr_checker.sv
verif/tb_top.sv
